// File: design/rsp_pkg.sv
// rsp_pkg: shared types, widths and constants of the rank select block
`timescale 1ns / 1ps

package rsp_pkg;

  localparam int RANK_W     = 10;
  localparam int VALUE_W    = 32;
  localparam int LCNT_W     = 11;
  localparam int ICNT_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int WORD_W     = 64;
  localparam int BIT_W      = 6;
  localparam int PCNT_W     = 7;
  localparam int RESET_ITEM_COUNT = 1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT  = 2'd1;

  typedef logic [RANK_W-1:0]         rank_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [LCNT_W-1:0]         lcnt_t;
  typedef logic [WORD_W-1:0]         word_t;
  typedef logic [BIT_W-1:0]          bitpos_t;
  typedef logic [PCNT_W-1:0]         pcnt_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_SCAN,
    ST_SELECT,
    ST_WRITE,
    ST_DONE
  } state_t;

  // number of set bits in one map word
  function automatic pcnt_t popcnt(input word_t w);
    pcnt_t c;
    c = '0;
    for (int i = 0; i < WORD_W; i++) begin
      c = c + pcnt_t'(w[i]);
    end
    return c;
  endfunction

  // mask of the k low bits
  function automatic word_t low_mask(input bitpos_t k);
    return (word_t'(1) << k) - word_t'(1);
  endfunction

endpackage

// File: design/rsp_in_if.sv
// rsp_in_if: request channel carrying one rank
`timescale 1ns / 1ps

interface rsp_in_if;
  logic          valid;
  logic          ready;
  rsp_pkg::rank_t rank;

  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);
endinterface

// File: design/rsp_out_if.sv
// rsp_out_if: result channel carrying the removed value and the count left
`timescale 1ns / 1ps

interface rsp_out_if;
  logic            valid;
  logic            ready;
  rsp_pkg::value_t value;
  logic            ok;
  rsp_pkg::lcnt_t  left_count;

  modport source (output valid, output value, output ok, output left_count, input ready);
  modport sink   (input valid, input value, input ok, input left_count, output ready);
endinterface

// File: design/rank_select_pop_top.sv
// rank_select_pop_top: select and remove the n-th smallest remaining integer
`timescale 1ns / 1ps

// The block keeps the integers first_value .. first_value+item_count-1 that
// are still undrawn, as a presence map of MAX_ITEMS bits held in a memory of
// 64-bit words. in_ch carries one rank per request; out_ch returns the
// removed value, ok, and the number of integers left. A rank at or above
// the count left returns ok low, value zero and removes nothing.
// Configuration: cfg_we with cfg_index selects first_value or item_count;
// writing item_count refills the map.
// A request runs through the word scan, the bit search and the write-back
// before its result is registered; an out-of-range rank skips all three.
// The word scan reads one map word per cycle through the single memory read
// port and subtracts its popcount from the rank; the bit inside the word is
// then found by a 6-step halving search with the same popcount unit, and
// the cleared word is written back. One request is in work at a time: the
// next one is taken only once the last result is in the output register.
// Reset (synchronous, rst_n low) and each item_count write start a fill
// pass that writes the NWORDS map words in turn (16 at the default size),
// during which no request is taken. A finished result sits in an output
// register: the next request is accepted while it waits, and a stalled
// receiver only holds back the result after that one.

module rank_select_pop_top #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rsp_in_if.sink                            in_ch,
  rsp_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int NWORDS  = (MAX_ITEMS + 63) / 64;
  localparam int WADDR_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int RESET_FILL = (rsp_pkg::RESET_ITEM_COUNT > MAX_ITEMS) ?
                              MAX_ITEMS : rsp_pkg::RESET_ITEM_COUNT;
  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NWORDS - 1);

  // sequencer and bookkeeping
  rsp_pkg::state_t       state_r, state_nxt;
  rsp_pkg::value_t       first_value_r, first_value_nxt;
  logic [CNT_W-1:0]      fill_n_r, fill_n_nxt;
  logic [CNT_W-1:0]      remaining_r, remaining_nxt;
  logic [WADDR_W-1:0]    fill_w_r, fill_w_nxt;

  // working registers of one request
  logic [WADDR_W-1:0]    wcnt_r, wcnt_nxt;
  rsp_pkg::rank_t        n_r, n_nxt;
  rsp_pkg::word_t        wrd_r, wrd_nxt;
  rsp_pkg::word_t        win_r, win_nxt;
  rsp_pkg::bitpos_t      pos_r, pos_nxt;
  logic [2:0]            step_r, step_nxt;
  rsp_pkg::value_t       res_value_r, res_value_nxt;
  logic                  res_ok_r, res_ok_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  rsp_pkg::value_t       out_value_r, out_value_nxt;
  logic                  out_ok_r, out_ok_nxt;
  rsp_pkg::lcnt_t        out_left_r, out_left_nxt;

  // map memory
  rsp_pkg::word_t        mem [NWORDS];
  rsp_pkg::word_t        rd_data_r;
  logic                  mem_we, mem_re;
  logic [WADDR_W-1:0]    mem_waddr, mem_raddr;
  rsp_pkg::word_t        mem_wdata;

  // shared popcount / compare unit
  rsp_pkg::word_t        pc_src;
  rsp_pkg::pcnt_t        pc;
  logic                  pc_hit;
  rsp_pkg::bitpos_t      half;

  logic                  in_acc;
  logic                  cnt_wr;
  logic                  out_free;
  logic                  rank_oob;
  logic [31:0]           fill_base, fill_lim, cfg_cnt, rem32;
  rsp_pkg::word_t        fill_word;
  logic [CNT_W-1:0]      cfg_fill;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cnt_wr   = cfg_we && (cfg_index == rsp_pkg::CFG_ITEM_COUNT);
  assign out_free = !out_valid_r || out_ch.ready;
  assign rank_oob = 32'(in_ch.rank) >= 32'(remaining_r);

  // item_count takes the low ICNT_W bits of cfg_wdata and saturates at the map size
  assign cfg_cnt  = 32'(cfg_wdata[rsp_pkg::ICNT_W-1:0]);
  assign cfg_fill = (cfg_cnt > 32'(MAX_ITEMS)) ? CNT_W'(MAX_ITEMS) : CNT_W'(cfg_cnt);

  // word of the refilled map at fill_w_r
  assign fill_base = 32'(fill_w_r) << rsp_pkg::BIT_W;
  assign fill_lim  = 32'(fill_n_r);
  always_comb begin
    if (fill_lim >= fill_base + 32'(rsp_pkg::WORD_W)) begin
      fill_word = '1;
    end else if (fill_lim <= fill_base) begin
      fill_word = '0;
    end else begin
      fill_word = rsp_pkg::low_mask(rsp_pkg::bitpos_t'(fill_lim - fill_base));
    end
  end

  // popcount feeds either the whole scanned word or the low half of the window
  assign half   = rsp_pkg::bitpos_t'(6'd32 >> step_r);
  assign pc_src = (state_r == rsp_pkg::ST_SCAN) ? rd_data_r :
                  (win_r & rsp_pkg::low_mask(half));
  assign pc     = rsp_pkg::popcnt(pc_src);
  assign pc_hit = 32'(n_r) < 32'(pc);

  assign rem32  = 32'(remaining_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsp_pkg::ST_FILL: begin
        if (fill_w_r == LAST_WORD) state_nxt = rsp_pkg::ST_IDLE;
      end
      rsp_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = rank_oob ? rsp_pkg::ST_DONE : rsp_pkg::ST_SCAN;
      end
      rsp_pkg::ST_SCAN: begin
        if (pc_hit) state_nxt = rsp_pkg::ST_SELECT;
      end
      rsp_pkg::ST_SELECT: begin
        if (step_r == 3'd5) state_nxt = rsp_pkg::ST_WRITE;
      end
      rsp_pkg::ST_WRITE: begin
        state_nxt = rsp_pkg::ST_DONE;
      end
      rsp_pkg::ST_DONE: begin
        if (out_free) state_nxt = rsp_pkg::ST_IDLE;
      end
      default: state_nxt = rsp_pkg::ST_FILL;
    endcase
    // an item_count write restarts the fill pass
    if (cnt_wr) state_nxt = rsp_pkg::ST_FILL;
  end

  // datapath and memory control
  always_comb begin
    first_value_nxt = first_value_r;
    fill_n_nxt      = fill_n_r;
    remaining_nxt   = remaining_r;
    fill_w_nxt      = fill_w_r;
    wcnt_nxt        = wcnt_r;
    n_nxt           = n_r;
    wrd_nxt         = wrd_r;
    win_nxt         = win_r;
    pos_nxt         = pos_r;
    step_nxt        = step_r;
    res_value_nxt   = res_value_r;
    res_ok_nxt      = res_ok_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_value_nxt   = out_value_r;
    out_ok_nxt      = out_ok_r;
    out_left_nxt    = out_left_r;
    mem_we          = 1'b0;
    mem_waddr       = fill_w_r;
    mem_wdata       = fill_word;
    mem_re          = 1'b0;
    mem_raddr       = '0;

    unique case (state_r)
      rsp_pkg::ST_FILL: begin
        mem_we     = 1'b1;
        fill_w_nxt = fill_w_r + 1'b1;
      end
      rsp_pkg::ST_IDLE: begin
        if (in_acc) begin
          n_nxt    = in_ch.rank;
          wcnt_nxt = '0;
          mem_re   = 1'b1;
          // preset result for an out-of-range rank: answered at once, map untouched
          res_value_nxt = '0;
          res_ok_nxt    = 1'b0;
        end
      end
      rsp_pkg::ST_SCAN: begin
        if (pc_hit) begin
          wrd_nxt  = rd_data_r;
          win_nxt  = rd_data_r;
          pos_nxt  = '0;
          step_nxt = '0;
        end else begin
          n_nxt     = n_r - rsp_pkg::rank_t'(pc);
          wcnt_nxt  = wcnt_r + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = wcnt_r + 1'b1;
        end
      end
      rsp_pkg::ST_SELECT: begin
        // halving search: keep the low half or skip past it
        if (!pc_hit) begin
          n_nxt   = n_r - rsp_pkg::rank_t'(pc);
          win_nxt = win_r >> half;
          pos_nxt = pos_r + half;
        end
        step_nxt = step_r + 3'd1;
      end
      rsp_pkg::ST_WRITE: begin
        mem_we        = 1'b1;
        mem_waddr     = wcnt_r;
        mem_wdata     = wrd_r & ~(rsp_pkg::word_t'(1) << pos_r);
        remaining_nxt = remaining_r - 1'b1;
        res_value_nxt = first_value_r + rsp_pkg::value_t'({wcnt_r, pos_r});
        res_ok_nxt    = 1'b1;
      end
      rsp_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_value_r;
          out_ok_nxt    = res_ok_r;
          out_left_nxt  = rem32[rsp_pkg::LCNT_W-1:0];
        end
      end
      default: ;
    endcase

    // configuration writes
    if (cfg_we && (cfg_index == rsp_pkg::CFG_FIRST_VALUE)) begin
      first_value_nxt = rsp_pkg::value_t'(cfg_wdata);
    end
    if (cnt_wr) begin
      fill_n_nxt    = cfg_fill;
      remaining_nxt = cfg_fill;
      fill_w_nxt    = '0;
    end
  end

  // map memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rsp_pkg::ST_FILL;
      first_value_r <= '0;
      fill_n_r      <= CNT_W'(RESET_FILL);
      remaining_r   <= CNT_W'(RESET_FILL);
      fill_w_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      first_value_r <= first_value_nxt;
      fill_n_r      <= fill_n_nxt;
      remaining_r   <= remaining_nxt;
      fill_w_r      <= fill_w_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    wcnt_r      <= wcnt_nxt;
    n_r         <= n_nxt;
    wrd_r       <= wrd_nxt;
    win_r       <= win_nxt;
    pos_r       <= pos_nxt;
    step_r      <= step_nxt;
    res_value_r <= res_value_nxt;
    res_ok_r    <= res_ok_nxt;
    out_value_r <= out_value_nxt;
    out_ok_r    <= out_ok_nxt;
    out_left_r  <= out_left_nxt;
  end

  assign in_ch.ready       = (state_r == rsp_pkg::ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = out_value_r;
  assign out_ch.ok         = out_ok_r;
  assign out_ch.left_count = out_left_r;

endmodule

// File: design/rsp_checker.sv
// rsp_checker: port-level assertions for rank_select_pop_top, with bind
`timescale 1ns / 1ps

module rsp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input rsp_pkg::value_t               out_value,
  input logic                          out_ok,
  input rsp_pkg::lcnt_t                out_left_count,
  input logic                          cfg_we,
  input logic [rsp_pkg::CFG_IDX_W-1:0] cfg_index
);

  // one request at a time
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous one still in work");

  // a rejected rank carries a zero value
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_value == '0)
    else $error("out-of-range result with nonzero value");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_ok)
      && $stable(out_left_count))
    else $error("result changed while stalled");

  // item_count write starts a refill, no request taken meanwhile
  a_refill_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == rsp_pkg::CFG_ITEM_COUNT |=> !in_ready)
    else $error("request port open right after refill start");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rank_select_pop_top rsp_checker u_rsp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_value      (out_ch.value),
  .out_ok         (out_ch.ok),
  .out_left_count (out_ch.left_count),
  .cfg_we         (cfg_we),
  .cfg_index      (cfg_index)
);
